// ===== sv/wfg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and the sine table generator of the waveform generator.
// No dependencies; the top level, multiplier and sine table take names from here by scope.

package wfg_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAVE_TYPE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FREQUENCY    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AMPLITUDE    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELTA_MODE   = 3'd5;

  // Wave type codes
  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [2:0] WAVE_SQUARE   = 3'd2;
  localparam logic [2:0] WAVE_SAW      = 3'd3;
  localparam logic [2:0] WAVE_INV_SAW  = 3'd4;

  // Register reset values
  localparam logic [31:0] FREQ_RESET = 32'h0001_0000;
  localparam logic [31:0] AMP_RESET  = 32'h0001_0000;

  // Wave value plus one, in Q16.16 (0 .. 2.0)
  localparam int          WV_BITS = 19;
  localparam logic [18:0] WV_ONE  = 19'd65536;
  localparam logic [18:0] WV_TWO  = 19'd131072;

  // Shared multiplier operand width (33 x 33 signed)
  localparam int MUL_W = 33;

  // Sine table entry width (0 .. 65536)
  localparam int SIN_W = 17;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Entry i of the quarter-wave table: sin(i/2^abits * pi/2) in Q16.16,
  // from a Q2.30 Taylor series to x^15, rounded half up and clamped.
  function automatic logic [SIN_W-1:0] sine_entry(input int unsigned idx,
                                                  input int unsigned abits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          e;
    int              k;
    x    = (longint'(idx) * HALF_PI_Q30) >> abits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 7; k++) begin
      term = (term * x2) >> 30;
      case (k)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        6:       term = term / 156;
        default: term = term / 210;
      endcase
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    e = (sum + 8192) >>> 14;
    if (e > 65536) e = 65536;
    return SIN_W'(e);
  endfunction

endpackage

// ===== sv/wfg_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the waveform generator: time request in,
// level result out. No dependencies.

interface wfg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_value;

  modport source (output valid, output time_value, input ready);
  modport sink   (input valid, input time_value, output ready);
endinterface

interface wfg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

// ===== sv/waveform_function_generator.sv =====
`timescale 1ns / 1ps
// Waveform function generator: top level with sequencer, phase and level datapath.
// Depends on wfg_pkg, wfg_chan_if, wfg_mult and wfg_sine_rom.
//
// Usage:
//   in_chan carries a time request (unsigned Q16.16, absolute time or a delta
//   when delta_mode is set); out_chan returns one level (signed Q16.16,
//   saturated) per request, in order. Both use valid/ready.
//   cfg_we/cfg_index/cfg_wdata write the six setup registers; write them only
//   while no request is in flight. Writing phase_offset also reloads the
//   phase accumulator.
//   A request passes the sequencer steps MUL1, PHASE, WAVE, MUL2 and DONE
//   in order; a new request is taken only once the last one has left DONE,
//   as one shared multiplier forms the phase product and later the amplitude
//   product, with the sine table read and wave shaping between them.
//   Reset (synchronous, rst_n low) loads the register defaults, clears the
//   accumulator and drops any pending request or result.
//   When the receiver stalls, the finished result sits in the output
//   register and the next request is still taken; a second result then waits
//   in the last sequencer step until the output register frees up.

module waveform_function_generator #(
  parameter int PHASE_BITS           = 16,
  parameter int SINE_TABLE_ADDR_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  wfg_in_if.sink                             in_chan,
  wfg_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [wfg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [31:0]                        cfg_wdata
);

  localparam int A     = SINE_TABLE_ADDR_BITS;
  localparam int TAB_N = 1 << A;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL1  = 6'b000010,
    ST_PHASE = 6'b000100,
    ST_WAVE  = 6'b001000,
    ST_MUL2  = 6'b010000,
    ST_DONE  = 6'b100000
  } wfg_state_t;

  wfg_state_t state_r, state_nxt;

  // Setup registers
  logic [2:0]         wave_type_r;
  logic signed [31:0] base_level_r;
  logic [31:0]        frequency_r;
  logic [15:0]        phase_offset_r;
  logic signed [31:0] amplitude_r;
  logic               delta_mode_r;

  // Datapath registers
  logic [PHASE_BITS-1:0] acc_r;
  logic [31:0]           t_r;
  logic [31:0]           u_r;
  logic [17:0]           wp1_r;
  logic                  out_valid_r;
  logic signed [31:0]    level_r;

  // Shared multiplier and table
  logic                              mul_en;
  logic signed [wfg_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [63:0]                       mul_p;
  logic [A:0]                        rom_addr;
  logic [wfg_pkg::SIN_W-1:0]         rom_data;

  logic [PHASE_BITS-1:0] off_al;
  logic [PHASE_BITS-1:0] frac;
  logic [PHASE_BITS-1:0] ph;
  logic [31:0]           u;
  logic [A-1:0]          tab_k;
  logic [wfg_pkg::WV_BITS-1:0] wv;
  logic signed [34:0]    lvl_sum;
  logic signed [31:0]    lvl_sat;
  logic                  out_free;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.level = level_r;
  assign out_free       = !out_valid_r || out_chan.ready;

  // Phase offset aligned to the phase width
  assign off_al = PHASE_BITS'({phase_offset_r, 16'h0000} >> (32 - PHASE_BITS));

  // Phase from the time * frequency fraction
  assign frac = PHASE_BITS'(mul_p[31:0] >> (32 - PHASE_BITS));
  assign ph   = delta_mode_r ? (acc_r + frac) : (frac + off_al);
  assign u    = 32'(ph) << (32 - PHASE_BITS);

  // Table address: mirror in the second and fourth quadrants
  assign tab_k    = u[29 -: A];
  assign rom_addr = u[30] ? ((A+1)'(TAB_N) - {1'b0, tab_k}) : {1'b0, tab_k};

  // Operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = {1'b0, t_r};
    mul_b  = {1'b0, frequency_r};
    case (state_r)
      ST_MUL1: begin
        mul_en = 1'b1;
      end
      ST_MUL2: begin
        mul_en = 1'b1;
        mul_a  = {15'd0, wp1_r};
        mul_b  = {amplitude_r[31], amplitude_r};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  wfg_mult u_mult (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  wfg_sine_rom #(
    .ADDR_BITS (A)
  ) u_rom (
    .clk    (clk),
    .en     (state_r == ST_PHASE),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  // Wave value plus one (0 .. 2.0 in Q16.16)
  always_comb begin
    case (wave_type_r)
      wfg_pkg::WAVE_SINE: begin
        wv = u_r[31] ? (wfg_pkg::WV_ONE - 19'(rom_data))
                     : (wfg_pkg::WV_ONE + 19'(rom_data));
      end
      wfg_pkg::WAVE_TRIANGLE: begin
        if (u_r < 32'h4000_0000) begin
          wv = wfg_pkg::WV_ONE + 19'(u_r >> 14);
        end else if (u_r < 32'hC000_0000) begin
          wv = wfg_pkg::WV_TWO - 19'((u_r - 32'h4000_0000) >> 14);
        end else begin
          wv = 19'((u_r - 32'hC000_0000) >> 14);
        end
      end
      wfg_pkg::WAVE_SQUARE: begin
        wv = (u_r <= 32'h8000_0000) ? wfg_pkg::WV_TWO : 19'd0;
      end
      wfg_pkg::WAVE_SAW: begin
        wv = 19'(u_r >> 15);
      end
      wfg_pkg::WAVE_INV_SAW: begin
        wv = wfg_pkg::WV_TWO - 19'(u_r >> 15);
      end
      default: begin
        wv = 19'd0;
      end
    endcase
  end

  // Level: base + floor(product / 2^17), saturated to 32 bits
  assign lvl_sum = 35'(base_level_r) + 35'($signed(mul_p[48:17]));
  always_comb begin
    if (lvl_sum[34:31] == 4'b0000 || lvl_sum[34:31] == 4'b1111) begin
      lvl_sat = lvl_sum[31:0];
    end else if (lvl_sum[34]) begin
      lvl_sat = 32'sh8000_0000;
    end else begin
      lvl_sat = 32'sh7FFF_FFFF;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) state_nxt = ST_MUL1;
      end
      ST_MUL1:  state_nxt = ST_PHASE;
      ST_PHASE: state_nxt = ST_WAVE;
      ST_WAVE:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state: sequencer, output valid, setup registers, accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      wave_type_r    <= wfg_pkg::WAVE_SINE;
      base_level_r   <= '0;
      frequency_r    <= wfg_pkg::FREQ_RESET;
      phase_offset_r <= '0;
      amplitude_r    <= wfg_pkg::AMP_RESET;
      delta_mode_r   <= 1'b0;
      acc_r          <= '0;
    end else begin
      state_r <= state_nxt;

      // Drop the result once taken, load a new one when free
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      // Advance the accumulator in delta mode
      if (state_r == ST_PHASE && delta_mode_r) begin
        acc_r <= ph;
      end

      // Setup writes
      if (cfg_we) begin
        case (cfg_index)
          wfg_pkg::CFG_WAVE_TYPE:  wave_type_r  <= cfg_wdata[2:0];
          wfg_pkg::CFG_BASE_LEVEL: base_level_r <= cfg_wdata;
          wfg_pkg::CFG_FREQUENCY:  frequency_r  <= cfg_wdata;
          wfg_pkg::CFG_PHASE_OFFSET: begin
            phase_offset_r <= cfg_wdata[15:0];
            acc_r          <= PHASE_BITS'({cfg_wdata[15:0], 16'h0000} >> (32 - PHASE_BITS));
          end
          wfg_pkg::CFG_AMPLITUDE:  amplitude_r  <= cfg_wdata;
          wfg_pkg::CFG_DELTA_MODE: delta_mode_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      t_r <= in_chan.time_value;
    end
    if (state_r == ST_PHASE) begin
      u_r <= u;
    end
    if (state_r == ST_WAVE) begin
      wp1_r <= wv[17:0];
    end
    if (state_r == ST_DONE && out_free) begin
      level_r <= lvl_sat;
    end
  end

endmodule

// ===== sv/wfg_mult.sv =====
`timescale 1ns / 1ps
// Shared 33 x 33 signed multiplier with registered product.
// Depends on wfg_pkg for the operand width.

module wfg_mult (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [wfg_pkg::MUL_W-1:0] a,
  input  logic signed [wfg_pkg::MUL_W-1:0] b,
  output logic        [63:0]               p_r
);

  // Full-width signed product
  logic signed [2*wfg_pkg::MUL_W-1:0] prod;

  assign prod = a * b;

  // Capture the low 64 bits of the product
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= prod[63:0];
    end
  end

endmodule

// ===== sv/wfg_sine_rom.sv =====
`timescale 1ns / 1ps
// Quarter-wave sine table with registered read, entries fixed at elaboration.
// Depends on wfg_pkg for the entry generator.

module wfg_sine_rom #(
  parameter int ADDR_BITS = 8
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ADDR_BITS:0]          addr,
  output logic [wfg_pkg::SIN_W-1:0]   data_r
);

  localparam int TAB_N = 1 << ADDR_BITS;

  logic [wfg_pkg::SIN_W-1:0] tab [TAB_N+1];

  // Build the constant table, one entry per point including the quarter end
  for (genvar g = 0; g <= TAB_N; g++) begin : g_tab
    localparam logic [wfg_pkg::SIN_W-1:0] ENTRY = wfg_pkg::sine_entry(g, ADDR_BITS);
    assign tab[g] = ENTRY;
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= tab[addr];
    end
  end

endmodule
